/* hdl/nmea_gga_sentence_extractor_top_assert.svh */
// Assertion macros for the GGA sentence extractor checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef NMEA_GGA_SENTENCE_EXTRACTOR_TOP_ASSERT_SVH
`define NMEA_GGA_SENTENCE_EXTRACTOR_TOP_ASSERT_SVH

// Clocked property check, off while in reset.
`define NGSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression that must never be true.
`define NGSE_ASSERT_NEVER(lbl, expr, msg) \
  `NGSE_ASSERT(lbl, !(expr), msg)

`endif

/* hdl/ngse_pkg.sv */
// Shared types, constants and helpers for the NMEA GGA sentence extractor.
// No dependencies.
package ngse_pkg;

  localparam int BUF_DEPTH   = 128;
  localparam int FIELD_LIMIT = 16;
  localparam int HEAD_LEN    = 5;

  localparam int LEN_W   = 8;
  localparam int SPLIT_W = 4;
  localparam int IDX_W   = 7;
  localparam int SENT_AW = $clog2(BUF_DEPTH);
  localparam int FIELD_AW = $clog2(FIELD_LIMIT);
  localparam int SENT_DEPTH  = 2 ** (SENT_AW + 1);
  localparam int FIELD_DEPTH = 2 ** (FIELD_AW + 1);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_A      = 8'h41;

  typedef enum logic [1:0] {
    ACT_BYTE = 2'd0,
    ACT_END  = 2'd1,
    ACT_READ = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [LEN_W-1:0]   sentence_length;
    logic [SPLIT_W-1:0] split_count;
    logic [7:0]         read_byte;
    logic [LEN_W-1:0]   field_start;
  } out_item_t;

  // Expected header "GPGGA" by position.
  function automatic logic [7:0] gga_head(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = CH_G;
      3'd1:    ch = CH_P;
      3'd2:    ch = CH_G;
      3'd3:    ch = CH_G;
      3'd4:    ch = CH_A;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

/* hdl/nmea_gga_sentence_extractor_top.sv */
// A result is registered and appears in the cycle after its input transfer.
// Throughput: one input transfer per cycle; input is stalled only while a
// result is held and the output side is stalling.
// Reset (async, active low) clears token and held-sentence control state;
// the two-bank byte and field-offset stores are not cleared.
// Depends on ngse_pkg.
module nmea_gga_sentence_extractor_top import ngse_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // Held sentence and token scan state.
  logic               held_bank_q, held_bank_d;
  logic               held_valid_q, held_valid_d;
  logic [LEN_W-1:0]   held_len_q, held_len_d;
  logic [SPLIT_W-1:0] held_splits_q, held_splits_d;
  logic [LEN_W-1:0]   tok_len_q, tok_len_d;
  logic [SPLIT_W-1:0] tok_splits_q, tok_splits_d;
  logic               header_ok_q, header_ok_d;
  logic [7:0]         prev_q, prev_d;
  logic               stopped_q, stopped_d;
  logic               fresh_q, fresh_d;

  // Output stage.
  logic               out_valid_q;
  logic [LEN_W-1:0]   o_len_q;
  logic [SPLIT_W-1:0] o_splits_q;
  logic               o_found_q;
  logic               rb_ok_q, fs_ok_q;
  logic [7:0]         rb_q;
  logic [LEN_W-1:0]   fs_q;

  logic [7:0]         sent_mem  [SENT_DEPTH];
  logic [LEN_W-1:0]   field_mem [FIELD_DEPTH];

  logic                  accept;
  logic                  tok_good;
  logic [7:0]            b;
  logic [LEN_W-1:0]      idx_ext;
  logic                  sent_we, field_we;
  logic [SENT_AW:0]      sent_waddr;
  logic [7:0]            sent_wdata;
  logic [FIELD_AW:0]     field_waddr;
  logic [LEN_W-1:0]      field_wdata;
  logic [SPLIT_W-1:0]    splits_inc;
  logic [LEN_W-1:0]      len_inc;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign b          = in_item_i.data_byte;
  assign idx_ext    = LEN_W'(in_item_i.read_index);
  assign tok_good   = (tok_len_q >= LEN_W'(HEAD_LEN)) & header_ok_q & (prev_q == CH_LF);
  assign splits_inc = tok_splits_q + SPLIT_W'(1);
  assign len_inc    = tok_len_q + LEN_W'(1);

  always_comb begin
    held_bank_d   = held_bank_q;
    held_valid_d  = held_valid_q;
    held_len_d    = held_len_q;
    held_splits_d = held_splits_q;
    tok_len_d     = tok_len_q;
    tok_splits_d  = tok_splits_q;
    header_ok_d   = header_ok_q;
    prev_d        = prev_q;
    stopped_d     = stopped_q;
    fresh_d       = fresh_q;
    sent_we       = 1'b0;
    field_we      = 1'b0;
    sent_waddr    = {~held_bank_q, tok_len_q[SENT_AW-1:0]};
    sent_wdata    = b;
    field_waddr   = {~held_bank_q, splits_inc[FIELD_AW-1:0]};
    field_wdata   = len_inc;

    case (action_e'(in_item_i.action))
      ACT_BYTE: begin
        if (fresh_q) begin
          held_valid_d  = 1'b0;
          held_len_d    = '0;
          held_splits_d = '0;
          fresh_d       = 1'b0;
        end
        if (!stopped_q) begin
          if (b == CH_NUL || b == CH_DOLLAR) begin
            // close token
            if (tok_good) begin
              held_bank_d   = ~held_bank_q;
              held_valid_d  = 1'b1;
              held_len_d    = tok_len_q;
              held_splits_d = tok_splits_q;
            end
            tok_len_d    = '0;
            tok_splits_d = '0;
            header_ok_d  = 1'b1;
            prev_d       = CH_NUL;
            if (b == CH_NUL) begin
              stopped_d = 1'b1;
            end
          end else begin
            if (tok_len_q < LEN_W'(BUF_DEPTH)) begin
              if (tok_len_q < LEN_W'(HEAD_LEN) && b != gga_head(tok_len_q[2:0])) begin
                header_ok_d = 1'b0;
              end
              if (b == CH_COMMA && tok_splits_q < SPLIT_W'(FIELD_LIMIT - 1)) begin
                sent_wdata   = CH_NUL;
                tok_splits_d = splits_inc;
                field_we     = 1'b1;
              end
              sent_we   = 1'b1;
              tok_len_d = len_inc;
            end
            prev_d = b;
          end
        end
      end
      ACT_END: begin
        if (fresh_q) begin
          held_valid_d  = 1'b0;
          held_len_d    = '0;
          held_splits_d = '0;
        end
        if (!stopped_q && tok_good) begin
          held_bank_d   = ~held_bank_q;
          held_valid_d  = 1'b1;
          held_len_d    = tok_len_q;
          held_splits_d = tok_splits_q;
        end
        tok_len_d    = '0;
        tok_splits_d = '0;
        header_ok_d  = 1'b1;
        prev_d       = CH_NUL;
        stopped_d    = 1'b0;
        fresh_d      = 1'b1;
      end
      default: begin
        // read only, no state change
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_bank_q   <= 1'b0;
      held_valid_q  <= 1'b0;
      held_len_q    <= '0;
      held_splits_q <= '0;
      tok_len_q     <= '0;
      tok_splits_q  <= '0;
      header_ok_q   <= 1'b1;
      prev_q        <= '0;
      stopped_q     <= 1'b0;
      fresh_q       <= 1'b1;
      out_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        held_bank_q   <= held_bank_d;
        held_valid_q  <= held_valid_d;
        held_len_q    <= held_len_d;
        held_splits_q <= held_splits_d;
        tok_len_q     <= tok_len_d;
        tok_splits_q  <= tok_splits_d;
        header_ok_q   <= header_ok_d;
        prev_q        <= prev_d;
        stopped_q     <= stopped_d;
        fresh_q       <= fresh_d;
        out_valid_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Writes go to the working bank, reads to the held bank, so a read in the
  // same transfer never sees the byte being written.
  always_ff @(posedge clk_i) begin
    if (accept && sent_we) begin
      sent_mem[sent_waddr] <= sent_wdata;
    end
    if (accept && field_we) begin
      field_mem[field_waddr] <= field_wdata;
    end
    if (accept) begin
      rb_q       <= sent_mem[{held_bank_d, idx_ext[SENT_AW-1:0]}];
      fs_q       <= field_mem[{held_bank_d, in_item_i.read_index[FIELD_AW-1:0]}];
      rb_ok_q    <= held_valid_d & (idx_ext < held_len_d);
      fs_ok_q    <= held_valid_d & (idx_ext != '0) &
                    (idx_ext <= LEN_W'(held_splits_d));
      o_found_q  <= held_valid_d;
      o_len_q    <= held_len_d;
      o_splits_q <= held_splits_d;
    end
  end

  assign out_valid_o                = out_valid_q;
  assign out_item_o.found           = o_found_q;
  assign out_item_o.sentence_length = o_len_q;
  assign out_item_o.split_count     = o_splits_q;
  assign out_item_o.read_byte       = rb_ok_q ? rb_q : 8'h00;
  assign out_item_o.field_start     = fs_ok_q ? fs_q : '0;

endmodule

/* hdl/ngse_checker.sv */
// Port-level checks for the GGA sentence extractor, bound to the top level.
// Depends on ngse_pkg and nmea_gga_sentence_extractor_top_assert.svh.
`include "nmea_gga_sentence_extractor_top_assert.svh"

module ngse_checker import ngse_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  `NGSE_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o), "result changed while stalled")
  `NGSE_ASSERT(a_transfer_result, in_valid_i && !in_stall_o |=> out_valid_o, "input transfer gave no result")
  `NGSE_ASSERT_NEVER(a_empty_nonzero, out_valid_o && !out_item_o.found && (out_item_o.sentence_length != '0 || out_item_o.split_count != '0 || out_item_o.read_byte != '0 || out_item_o.field_start != '0), "no sentence held but fields nonzero")
  `NGSE_ASSERT_NEVER(a_limits, out_valid_o && (out_item_o.sentence_length > LEN_W'(BUF_DEPTH) || out_item_o.split_count > SPLIT_W'(FIELD_LIMIT - 1) || out_item_o.field_start > out_item_o.sentence_length), "held sentence limits exceeded")

endmodule

bind nmea_gga_sentence_extractor_top ngse_checker u_ngse_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for nmea_gga_sentence_extractor_top: a directed table, then random
// receive buffers of GGA-like tokens; results match an in-bench model or a typed row's want.
// Depends on ngse_pkg and the extractor RTL.
module testbench;
  import ngse_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;  // undefined action code, behaves as a read
  localparam logic [8*HEAD_LEN-1:0] GGA_TAG = {CH_G, CH_P, CH_G, CH_G, CH_A};
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam int N_DIR = 19;
  localparam int N_RANDOM = 540;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam out_item_t NOTHING_HELD = '0;

  typedef enum int {TOK_GOOD, TOK_BAD_TAG, TOK_UNTERMINATED, TOK_SHORT, TOK_JUNK} token_kind_e;

  typedef struct packed {
    logic      typed;  // want holds a hand-written result
    in_item_t  stim;
    out_item_t want;
  } row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  nmea_gga_sentence_extractor_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // Directed rows: one GGA sentence held, a rejected token behind it, then an empty buffer.
  row_t dir_tab [N_DIR] = '{
    '{1'b1, '{ACT_READ, CH_NUL, 7'd0}, NOTHING_HELD},
    '{1'b0, '{ACT_BYTE, CH_DOLLAR, 7'd0}, '0},
    '{1'b0, '{ACT_BYTE, CH_G, 7'd0}, '0},
    '{1'b0, '{ACT_BYTE, CH_P, 7'd0}, '0},
    '{1'b0, '{ACT_BYTE, CH_G, 7'd0}, '0},
    '{1'b0, '{ACT_BYTE, CH_G, 7'd0}, '0},
    '{1'b0, '{ACT_BYTE, CH_A, 7'd0}, '0},
    '{1'b0, '{ACT_BYTE, CH_COMMA, 7'd6}, '0},
    '{1'b0, '{ACT_BYTE, CH_LF, 7'd1}, '0},
    '{1'b1, '{ACT_BYTE, CH_DOLLAR, 7'd1}, '{1'b1, 8'd7, 4'd1, CH_P, 8'd6}},
    '{1'b0, '{ACT_BYTE, 8'h58, 7'd3}, '0},
    '{1'b1, '{ACT_BYTE, CH_NUL, 7'd5}, '{1'b1, 8'd7, 4'd1, CH_NUL, 8'd0}},
    '{1'b1, '{ACT_BYTE, 8'hFF, 7'd127}, '{1'b1, 8'd7, 4'd1, CH_NUL, 8'd0}},
    '{1'b1, '{ACT_END, CH_NUL, 7'd6}, '{1'b1, 8'd7, 4'd1, CH_LF, 8'd0}},
    '{1'b1, '{ACT_SPARE, 8'hFF, 7'd0}, '{1'b1, 8'd7, 4'd1, CH_G, 8'd0}},
    '{1'b1, '{ACT_END, CH_NUL, 7'd0}, NOTHING_HELD},
    '{1'b1, '{ACT_READ, CH_NUL, 7'd1}, NOTHING_HELD},
    '{1'b0, '{ACT_BYTE, CH_NUL, 7'd0}, '0},
    '{1'b0, '{ACT_END, CH_NUL, 7'd127}, '0}
  };

  row_t      item_plan [$];
  out_item_t expected_reports [$];
  row_t      cur_row;
  out_item_t predicted;
  int        next_idx = 0;
  int        items_sent = 0;
  int        results_seen = 0;
  int        mismatches = 0;
  int        buffers_planned = 0;
  int        sentences_held = 0;
  int        truncated_held = 0;
  int        send_idle = 0;
  int        recv_idle = 0;
  int        quiet_cycles = 0;

  // Sentence model state
  logic [7:0]         sent_mem [2][BUF_DEPTH];
  logic [7:0]         fld_mem [2][FIELD_LIMIT];
  logic               m_bank = 1'b0;
  logic               m_valid = 1'b0;
  logic [LEN_W-1:0]   m_len = '0;
  logic [SPLIT_W-1:0] m_splits = '0;
  logic [LEN_W-1:0]   tok_len = '0;
  logic [SPLIT_W-1:0] tok_splits = '0;
  logic               hdr_ok = 1'b1;
  logic [7:0]         last_byte = CH_NUL;
  logic               scan_off = 1'b0;
  logic               fresh = 1'b1;

  function automatic void reset_token();
    tok_len = '0;
    tok_splits = '0;
    hdr_ok = 1'b1;
    last_byte = CH_NUL;
  endfunction

  function automatic void drop_held();
    m_valid = 1'b0;
    m_len = '0;
    m_splits = '0;
  endfunction

  function automatic void close_token();
    if (tok_len >= HEAD_LEN && hdr_ok && last_byte == CH_LF) begin
      m_bank = ~m_bank;
      m_valid = 1'b1;
      m_len = tok_len;
      m_splits = tok_splits;
      sentences_held++;
      if (tok_len == BUF_DEPTH) truncated_held++;
    end
    reset_token();
  endfunction

  task automatic extract_step(input in_item_t it, output out_item_t res);
    logic [7:0] b;
    logic [7:0] v;
    logic [IDX_W-1:0] idx;
    logic wbank;
    b = it.data_byte;
    idx = it.read_index;
    if (it.action == ACT_BYTE) begin
      if (fresh) begin
        drop_held();
        fresh = 1'b0;
      end
      if (!scan_off) begin
        if (b == CH_NUL) begin
          close_token();
          scan_off = 1'b1;
        end else if (b == CH_DOLLAR) begin
          close_token();
        end else begin
          if (tok_len < BUF_DEPTH) begin
            // tokens build in the bank that is not held
            wbank = ~m_bank;
            v = b;
            if (tok_len < HEAD_LEN && b != GGA_TAG[8*(HEAD_LEN-1-tok_len) +: 8]) hdr_ok = 1'b0;
            if (b == CH_COMMA && tok_splits < FIELD_LIMIT - 1) begin
              v = CH_NUL;
              tok_splits++;
              fld_mem[wbank][tok_splits] = tok_len + 8'd1;
            end
            sent_mem[wbank][tok_len] = v;
            tok_len++;
          end
          last_byte = b;
        end
      end
    end else if (it.action == ACT_END) begin
      if (fresh) drop_held();
      if (!scan_off) close_token();
      reset_token();
      scan_off = 1'b0;
      fresh = 1'b1;
    end
    res = '0;
    res.found = m_valid;
    res.sentence_length = m_len;
    res.split_count = m_splits;
    if (m_valid) begin
      if (idx < m_len) res.read_byte = sent_mem[m_bank][idx];
      if (idx >= 1 && idx <= m_splits) res.field_start = fld_mem[m_bank][idx[3:0]];
    end
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    int r;
    r = $urandom_range(99);
    if (r < 40) return IDX_W'($urandom_range(15));
    if (r < 80) return IDX_W'($urandom_range(40));
    return IDX_W'($urandom_range(127));
  endfunction

  function automatic logic [7:0] field_char();
    logic [7:0] c;
    case ($urandom_range(3))
      0, 1: c = 8'h30 + 8'($urandom_range(9));
      2: c = $urandom_range(1) ? "N" : ".";
      default: begin
        c = 8'($urandom_range(1, 255));
        while (c == CH_DOLLAR || c == CH_COMMA) c = 8'($urandom_range(1, 255));
      end
    endcase
    return c;
  endfunction

  task automatic push_read();
    row_t row;
    row = '0;
    row.stim.action = ACT_READ;
    if ($urandom_range(99) < 20) row.stim.action = ACT_SPARE;
    row.stim.data_byte = 8'($urandom_range(255));
    row.stim.read_index = pick_index();
    item_plan.push_back(row);
  endtask

  task automatic push_item(input logic [1:0] act, input logic [7:0] data);
    row_t row;
    row = '0;
    row.stim.action = act;
    row.stim.data_byte = data;
    row.stim.read_index = pick_index();
    item_plan.push_back(row);
    if (act == ACT_BYTE && $urandom_range(99) < 6) push_read();
  endtask

  task automatic add_token(input token_kind_e kind, input bit long_tok);
    int i;
    int n_tag;
    int bad_pos;
    int n_fields;
    int stored;
    int target;
    push_item(ACT_BYTE, CH_DOLLAR);
    if (kind == TOK_JUNK) begin
      repeat ($urandom_range(1, 12)) push_item(ACT_BYTE, field_char());
    end else if (kind == TOK_SHORT) begin
      n_tag = $urandom_range(HEAD_LEN - 1);
      for (i = 0; i < n_tag; i++) push_item(ACT_BYTE, GGA_TAG[8*(HEAD_LEN-1-i) +: 8]);
      push_item(ACT_BYTE, CH_LF);
    end else begin
      bad_pos = (kind == TOK_BAD_TAG) ? $urandom_range(HEAD_LEN - 1) : HEAD_LEN;
      for (i = 0; i < HEAD_LEN; i++) begin
        if (i == bad_pos)
          push_item(ACT_BYTE, GGA_TAG[8*(HEAD_LEN-1-i) +: 8] ^ 8'($urandom_range(1, 255)));
        else
          push_item(ACT_BYTE, GGA_TAG[8*(HEAD_LEN-1-i) +: 8]);
      end
      stored = HEAD_LEN;
      n_fields = long_tok ? 20 : $urandom_range(FIELD_LIMIT);
      target = long_tok ? $urandom_range(BUF_DEPTH + 1, BUF_DEPTH + 12) : 0;
      for (i = 0; i < n_fields || stored < target; i++) begin
        push_item(ACT_BYTE, CH_COMMA);
        stored++;
        repeat (long_tok ? $urandom_range(3, 8) : $urandom_range(5)) begin
          push_item(ACT_BYTE, field_char());
          stored++;
        end
      end
      if (kind == TOK_UNTERMINATED) begin
        if ($urandom_range(1)) push_item(ACT_BYTE, CH_LF);
        push_item(ACT_BYTE, field_char());
      end else begin
        if ($urandom_range(1)) push_item(ACT_BYTE, CH_CR);
        push_item(ACT_BYTE, CH_LF);
      end
    end
  endtask

  task automatic add_buffer(input bit first_random);
    int n_tok;
    int t;
    int r;
    buffers_planned++;
    if (!first_random && $urandom_range(99) < 8) begin
      repeat ($urandom_range(4, 20)) push_item(2'($urandom_range(3)), 8'($urandom_range(255)));
    end else begin
      if ($urandom_range(99) < 15) repeat ($urandom_range(1, 4)) push_item(ACT_BYTE, field_char());
      n_tok = ($urandom_range(99) < 8) ? 0 : $urandom_range(1, 3);
      for (t = 0; t < n_tok; t++) begin
        r = $urandom_range(99);
        if (first_random && t == 0)
          add_token(TOK_GOOD, 1'b1);  // truncated sentence, past the field limit
        else if (r < 60)
          add_token(TOK_GOOD, $urandom_range(99) < 3);
        else if (r < 72)
          add_token(TOK_BAD_TAG, $urandom_range(99) < 3);
        else if (r < 84)
          add_token(TOK_UNTERMINATED, $urandom_range(99) < 3);
        else if (r < 92)
          add_token(TOK_SHORT, 1'b0);
        else
          add_token(TOK_JUNK, 1'b0);
      end
      if ($urandom_range(99) < 25) begin
        push_item(ACT_BYTE, CH_NUL);
        repeat ($urandom_range(3)) push_item(ACT_BYTE, 8'($urandom_range(255)));
      end
    end
    push_item(ACT_END, 8'($urandom_range(255)));
    repeat ($urandom_range(1, 4)) push_read();
  endtask

  task automatic check_result(input out_item_t got, input out_item_t want);
    if (got.found !== want.found || got.sentence_length !== want.sentence_length ||
        got.split_count !== want.split_count || got.read_byte !== want.read_byte ||
        got.field_start !== want.field_start) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result %0d: want found=%0d len=%0d splits=%0d byte=%02h field=%0d, got found=%0d len=%0d splits=%0d byte=%02h field=%0d",
                 results_seen, want.found, want.sentence_length, want.split_count,
                 want.read_byte, want.field_start, got.found, got.sentence_length,
                 got.split_count, got.read_byte, got.field_start);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        extract_step(cur_row.stim, predicted);
        expected_reports.push_back(cur_row.typed ? cur_row.want : predicted);
        items_sent++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing outstanding", results_seen);
        end else begin
          check_result(out_item_o, expected_reports.pop_front());
        end
        results_seen++;
      end
      // idle mix: sender-heavy, receiver-heavy, then back to back
      if (next_idx < item_plan.size() / 3) begin
        send_idle = 27;
        recv_idle = 46;
      end else if (next_idx < 2 * item_plan.size() / 3) begin
        send_idle = 46;
        recv_idle = 27;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (next_idx < item_plan.size() && $urandom_range(99) >= send_idle) begin
          cur_row = item_plan[next_idx];
          next_idx++;
          in_item_i <= cur_row.stim;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles, %0d of %0d items sent", quiet_cycles, items_sent,
               item_plan.size());
      $display("nmea_gga_sentence_extractor_top test failed");
      $finish;
    end
  end

  initial begin
    int i;
    for (i = 0; i < N_DIR; i++) item_plan.push_back(dir_tab[i]);
    add_buffer(1'b1);
    while (item_plan.size() < N_DIR + N_RANDOM) add_buffer(1'b0);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (!(items_sent == item_plan.size() && expected_reports.size() == 0));
    // each result is registered in the DUT; spare cycles catch stray results
    repeat (4) @(posedge clk_i);
    $display("checked %0d results from %0d items over %0d receive buffers",
             results_seen, item_plan.size(), buffers_planned);
    $display("%0d sentences captured, %0d cut at buffer depth, %0d mismatches",
             sentences_held, truncated_held, mismatches);
    if (mismatches == 0)
      $display("nmea_gga_sentence_extractor_top test passed");
    else
      $display("nmea_gga_sentence_extractor_top test failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/ngse_pkg.sv
hdl/nmea_gga_sentence_extractor_top.sv
hdl/ngse_checker.sv
tb/testbench.sv
